/* design/pp3_pkg.sv */
// pp3_pkg: shared types and constants for the 3d polygon perimeter block
// no dependencies; used by polygon_perimeter_3d and the testbench top

package pp3_pkg;

   // width of the perimeter result field
   localparam int PERIM_WIDTH = 40;

   // sequencer states of the top level
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SQUARE,
      ST_ROOT,
      ST_ACCUM,
      ST_EMIT
   } seq_state_type;

endpackage

/* design/pp3_sqsum.sv */
// pp3_sqsum: absolute coordinate differences and bit-serial sum of squares
// shift-and-add over one multiplier bit per cycle; no package dependencies

module pp3_sqsum #(
   parameter int COORD_WIDTH = 24
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic signed [COORD_WIDTH-1:0]  a_x,
   input  logic signed [COORD_WIDTH-1:0]  a_y,
   input  logic signed [COORD_WIDTH-1:0]  a_z,
   input  logic signed [COORD_WIDTH-1:0]  b_x,
   input  logic signed [COORD_WIDTH-1:0]  b_y,
   input  logic signed [COORD_WIDTH-1:0]  b_z,
   output logic [2*COORD_WIDTH+3:0]       radicand,
   output logic                           done
);

   localparam int DW = COORD_WIDTH + 1;       // magnitude width of a difference
   localparam int AW = 2 * COORD_WIDTH + 4;   // sum of three squares
   localparam int CNTW = $clog2(DW);

   logic [DW-1:0]   dx_ff, dy_ff, dz_ff;
   logic [DW-1:0]   dx_in, dy_in, dz_in;
   logic [DW-1:0]   mx_ff, my_ff, mz_ff;
   logic [DW-1:0]   mx_in, my_in, mz_in;
   logic [AW-1:0]   acc_ff, acc_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic            busy_ff, busy_in;
   logic            done_ff, done_in;

   logic signed [DW-1:0] diff_x, diff_y, diff_z;
   logic [DW-1:0]        mag_x, mag_y, mag_z;
   logic [DW-1:0]        add_x, add_y, add_z;
   logic [DW+2:0]        part;

   // magnitudes of the coordinate differences
   always_comb begin
      diff_x = DW'(a_x) - DW'(b_x);
      diff_y = DW'(a_y) - DW'(b_y);
      diff_z = DW'(a_z) - DW'(b_z);
      mag_x  = diff_x[DW-1] ? DW'(-diff_x) : DW'(diff_x);
      mag_y  = diff_y[DW-1] ? DW'(-diff_y) : DW'(diff_y);
      mag_z  = diff_z[DW-1] ? DW'(-diff_z) : DW'(diff_z);
   end

   // one multiplier bit of each square per cycle, lsb first
   always_comb begin
      add_x = mx_ff[0] ? dx_ff : '0;
      add_y = my_ff[0] ? dy_ff : '0;
      add_z = mz_ff[0] ? dz_ff : '0;
      part  = {1'b0, acc_ff[AW-1:DW]} + {3'b000, add_x} + {3'b000, add_y}
            + {3'b000, add_z};
   end

   // next state of the serial multiplier
   always_comb begin
      dx_in   = dx_ff;
      dy_in   = dy_ff;
      dz_in   = dz_ff;
      mx_in   = mx_ff;
      my_in   = my_ff;
      mz_in   = mz_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         dx_in   = mag_x;
         dy_in   = mag_y;
         dz_in   = mag_z;
         mx_in   = mag_x;
         my_in   = mag_y;
         mz_in   = mag_z;
         acc_in  = '0;
         cnt_in  = CNTW'(DW - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = {part, acc_ff[DW-1:1]};
         mx_in  = mx_ff >> 1;
         my_in  = my_ff >> 1;
         mz_in  = mz_ff >> 1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      dx_ff  <= dx_in;
      dy_ff  <= dy_in;
      dz_ff  <= dz_in;
      mx_ff  <= mx_in;
      my_ff  <= my_in;
      mz_ff  <= mz_in;
      acc_ff <= acc_in;
      cnt_ff <= cnt_in;
   end

   assign radicand = acc_ff;
   assign done     = done_ff;

endmodule

/* design/pp3_isqrt.sv */
// pp3_isqrt: digit-serial integer square root, rounded down
// two radicand bits enter per cycle, one root bit leaves; no package dependencies

module pp3_isqrt #(
   parameter int IN_WIDTH = 52
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [IN_WIDTH-1:0]     radicand,
   output logic [IN_WIDTH/2-1:0]   root,
   output logic                    done
);

   localparam int RW = IN_WIDTH / 2;
   localparam int CNTW = $clog2(RW);

   logic [IN_WIDTH-1:0] rad_ff, rad_in;
   logic [RW:0]         rem_ff, rem_in;
   logic [RW-1:0]       root_ff, root_in;
   logic [CNTW-1:0]     cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;

   logic [RW+2:0] rem_shift;
   logic [RW+2:0] trial;
   logic [RW+2:0] rem_sub;

   // trial subtraction for the next root bit
   always_comb begin
      rem_shift = {rem_ff, rad_ff[IN_WIDTH-1:IN_WIDTH-2]};
      trial     = {1'b0, root_ff, 2'b01};
      rem_sub   = rem_shift - trial;
   end

   // next state of the root iteration
   always_comb begin
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = CNTW'(RW - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in = {rad_ff[IN_WIDTH-3:0], 2'b00};
         if (rem_shift >= trial) begin
            rem_in  = rem_sub[RW:0];
            root_in = {root_ff[RW-2:0], 1'b1};
         end else begin
            rem_in  = rem_shift[RW:0];
            root_in = {root_ff[RW-2:0], 1'b0};
         end
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
   end

   assign root = root_ff;
   assign done = done_ff;

endmodule

/* design/polygon_perimeter_3d.sv */
// polygon_perimeter_3d: perimeter of a closed 3d polygon from a vertex stream
// edge steps: each edge runs a load step, the bit-serial squaring unit, the root unit
//   and an add step, in that order
// vertex flow: no vertex is taken while an edge is in work; a final vertex runs its edge, then the closing edge
//   (only that if it opens the polygon), then loads the result register; a non-final opening vertex starts no edge
// reset: synchronous, active high; clears the sequencer, the polygon and the result beat

module polygon_perimeter_3d #(
   parameter int COORD_WIDTH = 24,
   parameter int SUM_WIDTH = 40,
   localparam int REQ_WIDTH = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [REQ_WIDTH-1:0]              req_tdata,  // coord_x, coord_y, coord_z, zero pad
   input  logic                              req_tlast,  // last_vertex
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [pp3_pkg::PERIM_WIDTH-1:0]   rsp_tdata,  // perimeter
   output logic [0:0]                        rsp_tuser   // overflow
);

   localparam int AW = 2 * COORD_WIDTH + 4;
   localparam int RW = AW / 2;
   localparam int EW = ((SUM_WIDTH > RW) ? SUM_WIDTH : RW) + 1;
   localparam int PW = pp3_pkg::PERIM_WIDTH;

   pp3_pkg::seq_state_type state_ff, state_in;

   logic signed [COORD_WIDTH-1:0] first_x_ff, first_y_ff, first_z_ff;
   logic signed [COORD_WIDTH-1:0] first_x_in, first_y_in, first_z_in;
   logic signed [COORD_WIDTH-1:0] prev_x_ff, prev_y_ff, prev_z_ff;
   logic signed [COORD_WIDTH-1:0] prev_x_in, prev_y_in, prev_z_in;
   logic signed [COORD_WIDTH-1:0] cur_x_ff, cur_y_ff, cur_z_ff;
   logic signed [COORD_WIDTH-1:0] cur_x_in, cur_y_in, cur_z_in;
   logic [SUM_WIDTH-1:0]          sum_ff, sum_in;
   logic                          sat_ff, sat_in;
   logic                          have_first_ff, have_first_in;
   logic                          last_ff, last_in;
   logic                          closing_ff, closing_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [PW-1:0]                 perim_ff, perim_in;
   logic                          ovf_ff, ovf_in;

   logic signed [COORD_WIDTH-1:0] in_x, in_y, in_z;
   logic signed [COORD_WIDTH-1:0] b_x, b_y, b_z;
   logic                          accept;
   logic                          sq_start, sq_done;
   logic                          rt_start, rt_done;
   logic                          do_load, do_accum, fire;
   logic [AW-1:0]                 radicand;
   logic [RW-1:0]                 root;
   logic [EW-1:0]                 sum_ext;
   logic [PW+SUM_WIDTH-1:0]       sum_wide;

   // vertex fields from the input beat
   assign in_x   = $signed(req_tdata[COORD_WIDTH-1:0]);
   assign in_y   = $signed(req_tdata[2*COORD_WIDTH-1:COORD_WIDTH]);
   assign in_z   = $signed(req_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH]);
   assign accept = req_tvalid & req_tready;

   // far end of the current edge: previous vertex or, for the closing edge, the first
   assign b_x = closing_ff ? first_x_ff : prev_x_ff;
   assign b_y = closing_ff ? first_y_ff : prev_y_ff;
   assign b_z = closing_ff ? first_z_ff : prev_z_ff;

   pp3_sqsum #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_sqsum (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .a_x      (cur_x_ff),
      .a_y      (cur_y_ff),
      .a_z      (cur_z_ff),
      .b_x      (b_x),
      .b_y      (b_y),
      .b_z      (b_z),
      .radicand (radicand),
      .done     (sq_done)
   );

   pp3_isqrt #(
      .IN_WIDTH (AW)
   ) u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (rt_start),
      .radicand (radicand),
      .root     (root),
      .done     (rt_done)
   );

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pp3_pkg::ST_IDLE: begin
            if (accept && (have_first_ff || req_tlast)) state_in = pp3_pkg::ST_LOAD;
         end
         pp3_pkg::ST_LOAD: begin
            state_in = pp3_pkg::ST_SQUARE;
         end
         pp3_pkg::ST_SQUARE: begin
            if (sq_done) state_in = pp3_pkg::ST_ROOT;
         end
         pp3_pkg::ST_ROOT: begin
            if (rt_done) state_in = pp3_pkg::ST_ACCUM;
         end
         pp3_pkg::ST_ACCUM: begin
            if (closing_ff) state_in = pp3_pkg::ST_EMIT;
            else if (last_ff) state_in = pp3_pkg::ST_LOAD;
            else state_in = pp3_pkg::ST_IDLE;
         end
         pp3_pkg::ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) state_in = pp3_pkg::ST_IDLE;
         end
         default: begin
            state_in = pp3_pkg::ST_IDLE;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_tready = 1'b0;
      do_load    = 1'b0;
      sq_start   = 1'b0;
      rt_start   = 1'b0;
      do_accum   = 1'b0;
      fire       = 1'b0;
      case (state_ff)
         pp3_pkg::ST_IDLE: begin
            req_tready = 1'b1;
         end
         pp3_pkg::ST_LOAD: begin
            do_load  = 1'b1;
            sq_start = 1'b1;
         end
         pp3_pkg::ST_SQUARE: begin
            rt_start = sq_done;
         end
         pp3_pkg::ST_ROOT: begin
         end
         pp3_pkg::ST_ACCUM: begin
            do_accum = 1'b1;
         end
         pp3_pkg::ST_EMIT: begin
            fire = !rsp_valid_ff || rsp_tready;
         end
         default: begin
         end
      endcase
   end

   // saturating add of an edge length
   assign sum_ext  = EW'(sum_ff) + EW'(root);
   assign sum_wide = {{PW{1'b0}}, sum_ff};

   // polygon state and result beat
   always_comb begin
      first_x_in    = first_x_ff;
      first_y_in    = first_y_ff;
      first_z_in    = first_z_ff;
      prev_x_in     = prev_x_ff;
      prev_y_in     = prev_y_ff;
      prev_z_in     = prev_z_ff;
      cur_x_in      = cur_x_ff;
      cur_y_in      = cur_y_ff;
      cur_z_in      = cur_z_ff;
      sum_in        = sum_ff;
      sat_in        = sat_ff;
      have_first_in = have_first_ff;
      last_in       = last_ff;
      closing_in    = closing_ff;
      perim_in      = perim_ff;
      ovf_in        = ovf_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;

      if (accept) begin
         cur_x_in   = in_x;
         cur_y_in   = in_y;
         cur_z_in   = in_z;
         last_in    = req_tlast;
         closing_in = !have_first_ff;
         if (!have_first_ff) begin
            first_x_in    = in_x;
            first_y_in    = in_y;
            first_z_in    = in_z;
            prev_x_in     = in_x;
            prev_y_in     = in_y;
            prev_z_in     = in_z;
            sum_in        = '0;
            sat_in        = 1'b0;
            have_first_in = 1'b1;
         end
      end

      if (do_load) begin
         prev_x_in = cur_x_ff;
         prev_y_in = cur_y_ff;
         prev_z_in = cur_z_ff;
      end

      if (do_accum) begin
         if (sum_ext > EW'({SUM_WIDTH{1'b1}})) begin
            sum_in = '1;
            sat_in = 1'b1;
         end else begin
            sum_in = sum_ext[SUM_WIDTH-1:0];
         end
         if (!closing_ff && last_ff) closing_in = 1'b1;
      end

      if (fire) begin
         perim_in      = sum_wide[PW-1:0];
         ovf_in        = sat_ff;
         rsp_valid_in  = 1'b1;
         sum_in        = '0;
         sat_in        = 1'b0;
         have_first_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= pp3_pkg::ST_IDLE;
         have_first_ff <= 1'b0;
         sum_ff        <= '0;
         sat_ff        <= 1'b0;
         last_ff       <= 1'b0;
         closing_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         have_first_ff <= have_first_in;
         sum_ff        <= sum_in;
         sat_ff        <= sat_in;
         last_ff       <= last_in;
         closing_ff    <= closing_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      first_x_ff <= first_x_in;
      first_y_ff <= first_y_in;
      first_z_ff <= first_z_in;
      prev_x_ff  <= prev_x_in;
      prev_y_ff  <= prev_y_in;
      prev_z_ff  <= prev_z_in;
      cur_x_ff   <= cur_x_in;
      cur_y_ff   <= cur_y_in;
      cur_z_ff   <= cur_z_in;
      perim_ff   <= perim_in;
      ovf_ff     <= ovf_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = perim_ff;
   assign rsp_tuser[0] = ovf_ff;

endmodule

/* tb/pp3_perimeter_checker.sv */
// pp3_perimeter_checker: watches the vertex and perimeter streams of polygon_perimeter_3d,
// predicts each closed-polygon perimeter and compares it with the beat that comes back
// depends on nothing but the port list of the block
`timescale 1ns / 1ps

module pp3_perimeter_checker #(
   parameter int COORD_W = 24,
   parameter int PERIM_W = 40
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [3*COORD_W-1:0]   req_tdata,  // coord_x, coord_y, coord_z
   input  logic                   req_tlast,  // last_vertex
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [PERIM_W-1:0]     rsp_tdata,  // perimeter
   input  logic [0:0]             rsp_tuser,  // overflow
   output int                     mismatch_count,
   output int                     outstanding,
   output int                     perims_checked
);

   typedef struct packed {
      logic [PERIM_W-1:0] perim;
      logic               ovf;
   } perim_beat_type;

   perim_beat_type perim_expected_q[$];

   // polygon state as the block should hold it
   logic signed [COORD_W-1:0] start_x, start_y, start_z;
   logic signed [COORD_W-1:0] last_x, last_y, last_z;
   logic [PERIM_W-1:0]        perim_acc;
   logic                      perim_sat;
   logic                      polygon_open;

   // magnitude of a coordinate difference, one bit wider than a coordinate
   function automatic logic [COORD_W:0] coord_gap(input logic signed [COORD_W-1:0] a,
                                                  input logic signed [COORD_W-1:0] b);
      logic signed [COORD_W:0] wa, wb, d;
      wa = a;
      wb = b;
      d = wa - wb;
      return (d < 0) ? -d : d;
   endfunction

   // floor of the euclidean distance between two vertices, in q.8 units
   function automatic logic [PERIM_W-1:0] edge_length_q8(
      input logic signed [COORD_W-1:0] ax, ay, az, bx, by, bz);
      logic [63:0] dx, dy, dz, sq_sum, trial, root;
      dx = 64'(coord_gap(ax, bx));
      dy = 64'(coord_gap(ay, by));
      dz = 64'(coord_gap(az, bz));
      sq_sum = dx * dx + dy * dy + dz * dz;
      root = '0;
      for (int b = COORD_W + 2; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= sq_sum) root = trial;
      end
      return root[PERIM_W-1:0];
   endfunction

   // saturating add into the running perimeter
   task automatic add_edge(input logic [PERIM_W-1:0] len);
      logic [PERIM_W:0] s;
      s = {1'b0, perim_acc} + {1'b0, len};
      if (s[PERIM_W]) begin
         perim_acc = '1;
         perim_sat = 1'b1;
      end else begin
         perim_acc = s[PERIM_W-1:0];
      end
   endtask

   // one accepted vertex: walk the edge, close the polygon on the final vertex
   task automatic take_vertex(input logic signed [COORD_W-1:0] x, y, z, input logic fin);
      perim_beat_type b;
      if (!polygon_open) begin
         start_x = x;
         start_y = y;
         start_z = z;
         perim_acc = '0;
         perim_sat = 1'b0;
         polygon_open = 1'b1;
      end else begin
         add_edge(edge_length_q8(x, y, z, last_x, last_y, last_z));
      end
      last_x = x;
      last_y = y;
      last_z = z;
      if (fin) begin
         add_edge(edge_length_q8(x, y, z, start_x, start_y, start_z));
         b.perim = perim_acc;
         b.ovf = perim_sat;
         perim_expected_q = {perim_expected_q, b};
         perim_acc = '0;
         perim_sat = 1'b0;
         polygon_open = 1'b0;
      end
   endtask

   // sample both channels at the rising edge
   always @(posedge clock) begin
      perim_beat_type want;
      if (reset) begin
         start_x = '0; start_y = '0; start_z = '0;
         last_x = '0; last_y = '0; last_z = '0;
         perim_acc = '0;
         perim_sat = 1'b0;
         polygon_open = 1'b0;
         perim_expected_q.delete();
         mismatch_count = 0;
         perims_checked = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (perim_expected_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: perimeter beat with none expected: perim %0d ovf %0d",
                           $realtime, rsp_tdata, rsp_tuser[0]);
            end else begin
               want = perim_expected_q.pop_front();
               perims_checked++;
               if (rsp_tdata !== want.perim || rsp_tuser[0] !== want.ovf) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("%0t: perimeter mismatch: expected %0d ovf %0d, got %0d ovf %0d",
                              $realtime, want.perim, want.ovf, rsp_tdata, rsp_tuser[0]);
               end
            end
         end
         if (req_tvalid && req_tready)
            take_vertex(req_tdata[COORD_W-1:0], req_tdata[2*COORD_W-1:COORD_W],
                        req_tdata[3*COORD_W-1:2*COORD_W], req_tlast);
      end
      outstanding = perim_expected_q.size();
   end

endmodule

/* tb/tb.sv */
// tb: top of the polygon_perimeter_3d testbench; drives vertex polygons under varying
// back-pressure and gives the verdict. depends on polygon_perimeter_3d, pp3_pkg
// and pp3_perimeter_checker
`timescale 1ns / 1ps

module tb;

   localparam int COORD_W = 24;
   localparam int REQ_W = 3 * COORD_W;
   localparam int PERIM_W = pp3_pkg::PERIM_WIDTH;
   localparam int LIMIT_CYCLES = 12_000_000;
   localparam int PHASE_VERTICES = 350;
   localparam int LONG_VERTICES = 200;
   localparam logic signed [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W-1){1'b0}}};
   localparam logic signed [COORD_W-1:0] C_MAX = {1'b0, {(COORD_W-1){1'b1}}};

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [REQ_W-1:0]   req_tdata = '0;  // coord_x, coord_y, coord_z
   logic               req_tlast = 1'b0;  // last_vertex
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [PERIM_W-1:0] rsp_tdata;  // perimeter
   logic [0:0]         rsp_tuser;  // overflow

   int mismatch_count, outstanding, perims_checked;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int vertices_sent = 0;
   int polygons_sent = 0;
   int cycle_count = 0;

   polygon_perimeter_3d u_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   pp3_perimeter_checker #(.COORD_W(COORD_W), .PERIM_W(PERIM_W)) u_checker (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .mismatch_count(mismatch_count),
      .outstanding(outstanding),
      .perims_checked(perims_checked)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("tb: timed out after %0d cycles", cycle_count);
         $display("tb: done, errors");
         $finish;
      end
   end

   // perimeter side back-pressure
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // one vertex beat, with random idle cycles ahead of it
   task automatic send_vertex(input logic signed [COORD_W-1:0] x, y, z, input logic fin);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {z, y, x};
      req_tlast <= fin;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      vertices_sent++;
      if (fin) polygons_sent++;
   endtask

   // coordinate of a given flavour: full range, near origin, corner values, mid range
   function automatic logic signed [COORD_W-1:0] pick_coord(input int flavour);
      logic signed [COORD_W-1:0] c;
      case (flavour)
         0: c = COORD_W'($urandom);
         1: c = COORD_W'($signed($urandom_range(2000)) - 1000);
         2: begin
            case ($urandom_range(3))
               0: c = C_MIN;
               1: c = C_MAX;
               2: c = '0;
               default: c = '1;
            endcase
         end
         default: c = COORD_W'($signed($urandom_range(65535)) - 32768);
      endcase
      return c;
   endfunction

   // a polygon of random length, mostly short, its vertices of one flavour or mixed
   task automatic send_random_polygon();
      int n, flavour;
      n = ($urandom_range(99) < 85) ? $urandom_range(1, 6) : $urandom_range(7, 40);
      flavour = $urandom_range(4);
      for (int i = 0; i < n; i++) begin
         if (flavour == 4)
            send_vertex(pick_coord($urandom_range(3)), pick_coord($urandom_range(3)),
                        pick_coord($urandom_range(3)), i == n - 1);
         else
            send_vertex(pick_coord(flavour), pick_coord(flavour), pick_coord(flavour),
                        i == n - 1);
      end
   endtask

   task automatic drain_perims();
      while (outstanding != 0) @(negedge clock);
   endtask

   initial begin
      int phase_start;
      int failures;

      // hold reset, then release it
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // single-vertex polygons, at the origin and at the far corner
      send_vertex(0, 0, 0, 1'b1);
      send_vertex(C_MIN, C_MIN, C_MIN, 1'b1);
      // two vertices: longest edge, counted out and back
      send_vertex(C_MIN, C_MIN, C_MIN, 1'b0);
      send_vertex(C_MAX, C_MAX, C_MAX, 1'b1);
      // triangle across the extremes
      send_vertex(C_MAX, C_MIN, 0, 1'b0);
      send_vertex(C_MIN, C_MAX, C_MAX, 1'b0);
      send_vertex(0, 0, C_MIN, 1'b1);
      // unit square in q16.8
      send_vertex(0, 0, 0, 1'b0);
      send_vertex(256, 0, 0, 1'b0);
      send_vertex(256, 256, 0, 1'b0);
      send_vertex(0, 256, 0, 1'b1);
      // zero-length edge
      send_vertex(5, -3, 7, 1'b0);
      send_vertex(5, -3, 7, 1'b1);
      // exact root, 1-2-2 gives 3
      send_vertex(-1, -2, -2, 1'b0);
      send_vertex(0, 0, 0, 1'b1);
      // all ones against mixed extremes
      send_vertex('1, '1, '1, 1'b0);
      send_vertex(C_MAX, 0, C_MIN, 1'b1);

      // hold off until every perimeter is back
      req_tvalid <= 1'b0;
      drain_perims();

      // long polygon of longest edges for a large running sum
      for (int i = 0; i < LONG_VERTICES; i++) begin
         if (i % 2 == 0)
            send_vertex(C_MIN, C_MIN, C_MIN, i == LONG_VERTICES - 1);
         else
            send_vertex(C_MAX, C_MAX, C_MAX, i == LONG_VERTICES - 1);
      end

      // random polygons under four idling mixes
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0; recv_stall_pct = 0; end
            1: begin send_idle_pct = 47; recv_stall_pct = 0; end
            2: begin send_idle_pct = 0; recv_stall_pct = 47; end
            default: begin send_idle_pct = 14; recv_stall_pct = 14; end
         endcase
         phase_start = vertices_sent;
         while (vertices_sent - phase_start < PHASE_VERTICES) send_random_polygon();
         req_tvalid <= 1'b0;
         drain_perims();
      end

      // quiet tail to catch any stray perimeter beat
      recv_stall_pct = 0;
      repeat (300) @(negedge clock);

      failures = mismatch_count + outstanding;
      $display("tb: %0d vertices in %0d polygons, %0d perimeters checked, %0d failures",
               vertices_sent, polygons_sent, perims_checked, failures);
      $display("tb: covered single and two-vertex polygons, extremes and a long polygon");
      if (failures == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

endmodule
